>>> hw/rtl/eml_pkg.sv
// Shared types, keyword trie tables and mask lookup for the event-mask keyword lexer.
`timescale 1ns / 1ps

package eml_pkg;

  localparam int NODE_COUNT = 112;
  localparam int NODE_W     = 7;
  localparam int CHAR_W     = 8;
  localparam int MASK_W     = 31;

  localparam logic [NODE_W-1:0] START_NODE = '0;
  localparam logic [NODE_W-1:0] LAST_NODE  = NODE_W'(NODE_COUNT - 1);

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_PIPE  = 8'h7C;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    KIND_END   = 2'd0,
    KIND_COMMA = 2'd1,
    KIND_PIPE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef struct packed {
    logic              emit;
    logic [MASK_W-1:0] mask;
    kind_t             kind;
  } eml_res_t;

  typedef struct packed {
    logic              hit;
    logic [MASK_W-1:0] mask;
  } eml_term_t;

  // Upper-case character that leads into each trie node; node 0 is the start.
  localparam logic [CHAR_W-1:0] NODE_CHAR [NODE_COUNT] = '{
    8'h00,
    "F", "A", "N", "_", "A", "C", "C", "E", "S", "S",
    "_", "P", "E", "R", "M",
    "M", "O", "D", "I", "F", "Y",
    "C", "L", "O", "S", "E",
    "_", "W", "R", "I", "T", "E",
    "N", "O", "W", "R", "I", "T", "E",
    "O", "P", "E", "N",
    "_", "P", "E", "R", "M",
    "Q", "_", "O", "V", "E", "R", "F", "L", "O", "W",
    "N", "D", "I", "R",
    "E", "V", "E", "N", "T", "_", "O", "N", "_", "C", "H", "I", "L", "D",
    "L", "L", "_", "E", "V", "E", "N", "T", "S",
    "P", "E", "R", "M", "_", "E", "V", "E", "N", "T", "S",
    "O", "U", "T", "G", "O", "I", "N", "G", "_", "E", "V", "E", "N", "T", "S"
  };

  // Parent node of each trie node. Most nodes continue the previous one; the
  // first node of each branch hangs off the node where its keyword leaves an earlier one.
  function automatic logic [NODE_W-1:0] node_parent(input logic [NODE_W-1:0] id);
    logic [NODE_W-1:0] p;
    p = id - NODE_W'(1);
    unique case (id)
      7'd16:   p = 7'd4;
      7'd22:   p = 7'd4;
      7'd33:   p = 7'd27;
      7'd40:   p = 7'd4;
      7'd49:   p = 7'd4;
      7'd63:   p = 7'd4;
      7'd59:   p = 7'd40;
      7'd77:   p = 7'd5;
      7'd86:   p = 7'd79;
      7'd97:   p = 7'd79;
      default: p = id - NODE_W'(1);
    endcase
    return p;
  endfunction

  // Nodes that complete a keyword, with that keyword's event mask.
  function automatic eml_term_t node_term(input logic [NODE_W-1:0] id);
    eml_term_t t;
    t.hit = 1'b1;
    unique case (id)
      7'd10:   t.mask = 31'h0000_0001;
      7'd15:   t.mask = 31'h0002_0000;
      7'd21:   t.mask = 31'h0000_0002;
      7'd26:   t.mask = 31'h0000_0018;
      7'd32:   t.mask = 31'h0000_0008;
      7'd39:   t.mask = 31'h0000_0010;
      7'd43:   t.mask = 31'h0000_0020;
      7'd48:   t.mask = 31'h0001_0000;
      7'd58:   t.mask = 31'h0000_4000;
      7'd62:   t.mask = 31'h4000_0000;
      7'd76:   t.mask = 31'h0800_0000;
      7'd85:   t.mask = 31'h0000_003B;
      7'd96:   t.mask = 31'h0003_0000;
      7'd111:  t.mask = 31'h0003_403B;
      default: begin
        t.hit  = 1'b0;
        t.mask = '0;
      end
    endcase
    return t;
  endfunction

endpackage

>>> hw/rtl/event_mask_keyword_lexer_top.sv
// Top level of the event-mask keyword lexer: input register, trie step and result register.
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// char      char_valid / char_stall     char_byte[7:0], line_last
// result    result_valid / result_stall event_mask[30:0], kind[1:0]
//
// One character word is taken every cycle while char_stall is low; its result, if
// any, is offered from the result register: acceptance loads the input register,
// and the trie step moves into the result register once that register is free.
// The trie step is a single lookup against the current node, so back-to-back
// characters wait only on a pending result, never on the trie itself.
// Reset returns the trie to its start node and empties both registers.
// A result waiting under result_stall holds up only a character that would
// itself produce a result; characters that just extend a keyword still flow.

module event_mask_keyword_lexer_top
  import eml_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_stall,
  input  logic [CHAR_W-1:0] char_byte,
  input  logic              line_last,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [MASK_W-1:0] event_mask,
  output logic [1:0]        kind
);

  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;
  logic              out_valid;
  logic [MASK_W-1:0] out_mask;
  kind_t             out_kind;

  logic              proceed;
  logic              consume;
  eml_res_t          res;

  eml_trie u_trie (
    .clk  (clk),
    .rst  (rst),
    .step (consume),
    .chr  (in_char),
    .last (in_last),
    .res  (res)
  );

  assign proceed    = !out_valid || !result_stall;
  assign consume    = in_valid && (proceed || !res.emit);
  assign char_stall = in_valid && !consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!char_stall) begin
      in_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      in_char <= char_byte;
      in_last <= line_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed) begin
      out_valid <= in_valid && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && in_valid && res.emit) begin
      out_mask <= res.mask;
      out_kind <= res.kind;
    end
  end

  assign result_valid = out_valid;
  assign event_mask   = out_mask;
  assign kind         = out_kind;

  a_error_mask_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_ERROR |-> out_mask == '0)
    else $error("error result carries a non-zero mask");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_valid && res.emit && out_valid && result_stall |-> char_stall)
    else $error("pending result would be overwritten");

  a_held_char: assert property (@(posedge clk) disable iff (rst)
    char_stall |=> in_valid && $stable(in_char) && $stable(in_last))
    else $error("held character word lost while stalled");

endmodule

>>> hw/rtl/eml_trie.sv
// Keyword trie: holds the matched-prefix node and works out one character step.
`timescale 1ns / 1ps

module eml_trie
  import eml_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [CHAR_W-1:0] chr,
  input  logic              last,
  output eml_res_t          res
);

  logic [NODE_W-1:0] match_state;
  logic [NODE_W-1:0] match_state_next;

  logic [CHAR_W-1:0] chr_up;
  logic              is_ws;
  logic              is_sep;
  logic              is_word_char;
  logic              moved;
  logic [NODE_W-1:0] child;
  eml_term_t         term;

  always_comb begin
    chr_up = chr;
    if (chr >= CH_LOW_A && chr <= CH_LOW_Z) begin
      chr_up = chr - CASE_OFS;
    end
  end

  assign is_ws = (chr_up == CH_SPACE) || (chr_up == CH_TAB) ||
                 (chr_up == CH_CR) || (chr_up == CH_LF);
  assign is_sep = is_ws || (chr_up == CH_COMMA) || (chr_up == CH_PIPE);
  assign is_word_char = ((chr_up >= CH_UP_A) && (chr_up <= CH_UP_Z)) ||
                        (chr_up == CH_UNDER);
  assign term = node_term(match_state);

  // The children of a node carry distinct characters, so at most one matches.
  always_comb begin
    moved = 1'b0;
    child = START_NODE;
    for (int n = 1; n < NODE_COUNT; n++) begin
      if (node_parent(NODE_W'(n)) == match_state && NODE_CHAR[n] == chr_up) begin
        moved = 1'b1;
        child = NODE_W'(n);
      end
    end
  end

  always_comb begin
    res.emit = 1'b0;
    res.mask = '0;
    res.kind = KIND_ERROR;
    if (is_sep) begin
      res.emit = 1'b1;
      if (match_state == START_NODE) begin
        if (is_ws) begin
          res.kind = KIND_END;
        end
      end else if (term.hit) begin
        res.mask = term.mask;
        priority if (chr_up == CH_COMMA) begin
          res.kind = KIND_COMMA;
        end else if (chr_up == CH_PIPE) begin
          res.kind = KIND_PIPE;
        end else begin
          res.kind = KIND_END;
        end
      end
    end else if (!(is_word_char && moved)) begin
      res.emit = 1'b1;
    end else if (last) begin
      res.emit = 1'b1;
    end
  end

  always_comb begin
    match_state_next = match_state;
    if (step) begin
      if (res.emit) begin
        match_state_next = START_NODE;
      end else begin
        match_state_next = child;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_state <= START_NODE;
    end else begin
      match_state <= match_state_next;
    end
  end

  a_start_after_result: assert property (@(posedge clk) disable iff (rst)
    step && res.emit |=> match_state == START_NODE)
    else $error("trie did not return to the start node after a result");

  a_node_in_range: assert property (@(posedge clk) disable iff (rst)
    match_state <= LAST_NODE)
    else $error("trie node outside the keyword trie");

endmodule
